// ===== src/vsrd_pkg.sv =====
// shared types, codes and helpers of the vector shape record decoder
`default_nettype none
package vsrd_pkg;

  localparam int unsigned BufWidth  = 40;
  localparam int unsigned HeldWidth = 6;
  localparam logic [HeldWidth-1:0] BufBits = 6'd40;

  // result kinds
  localparam logic [2:0] KIND_CHANGE = 3'd0;
  localparam logic [2:0] KIND_EDGE   = 3'd1;
  localparam logic [2:0] KIND_CURVE  = 3'd2;
  localparam logic [2:0] KIND_HEADER = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // parse phase, one-hot
  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_HEAD   = 6'b000010,
    PH_CHANGE = 6'b000100,
    PH_LINE   = 6'b001000,
    PH_CURVE  = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  // one input byte as held in the front queue
  typedef struct packed {
    logic       start_shape;
    logic [7:0] data_byte;
  } byte_t;

  // one result item
  typedef struct packed {
    logic [2:0]         record_kind;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] ctrl_x_out;
    logic signed [31:0] ctrl_y_out;
    logic [14:0]        fill_left;
    logic [14:0]        fill_right;
    logic [14:0]        stroke_style;
    logic               style_error;
    logic               last;
  } result_t;

  // sign extend an n-bit field, width zero reads as zero
  function automatic logic [31:0] sext(input logic [31:0] v, input logic [4:0] n);
    logic [31:0] m;
    m = (32'd1 << n) - 32'd1;
    if (n == 5'd0) return 32'd0;
    if (v[n-5'd1]) return v | ~m;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/vsrd_byte_queue.sv =====
// front queue of accepted stream bytes with their start marks
`default_nettype none
module vsrd_byte_queue
  import vsrd_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  byte_t push_data_i,
  output logic  full_o,
  input  wire   pop_i,
  output logic  valid_o,
  output byte_t data_o
);

  byte_t       mem_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, push_i} - {2'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

// ===== src/vsrd_result_queue.sv =====
// two-entry result queue that parts the decoder from the output stream
`default_nettype none
module vsrd_result_queue
  import vsrd_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     push_i,
  input  result_t push_data_i,
  output logic    full_o,
  input  wire     pop_i,
  output logic    valid_o,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

// ===== src/vsrd_engine.sv =====
// back end: bit accumulator and record parser, one field or record a cycle while the output side is not full
`default_nettype none
module vsrd_engine
  import vsrd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     byte_valid_i,
  input  byte_t   byte_i,
  output logic    byte_pop_o,
  input  wire     out_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  localparam int unsigned CW = COORD_WIDTH;

  logic [BufWidth-1:0]  buf_q, buf_d;
  logic [HeldWidth-1:0] held_q, held_d;
  phase_e               phase_q, phase_d;
  logic [3:0]           step_q, step_d;
  logic signed [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [4:0]           dw_q, dw_d;
  logic [4:0]           flags_q, flags_d;
  logic [14:0]          f0_q, f0_d, f1_q, f1_d, ln_q, ln_d;
  logic [3:0]           fib_q, fib_d, lib_q, lib_d;
  logic                 run_q, run_d;
  logic [1:0]           n_q, n_d;
  logic                 pend_vld_q, pend_vld_d;
  result_t              pend_q, pend_d;

  logic                 en;
  logic [2:0]           eff;
  logic [5:0]           act;
  logic                 stop, change_fin, short, end_byte;
  logic [4:0]           w;
  logic [HeldWidth-1:0] sh;
  logic [BufWidth-1:0]  shifted;
  logic [31:0]          v;
  logic [CW-1:0]        sx;
  logic                 emit;
  logic [2:0]           emit_kind;
  logic                 emit_ctrl;
  result_t              new_res;

  assign en = !out_full_i;

  // which change-record steps carry a field
  assign act[0] = flags_q[0];
  assign act[1] = flags_q[0];
  assign act[2] = flags_q[0];
  assign act[3] = flags_q[1];
  assign act[4] = flags_q[2];
  assign act[5] = flags_q[3];

  // first active change step at or after the current one
  always_comb begin
    eff = 3'd6;
    for (int i = 5; i >= 0; i--) begin
      if ((4'(i) >= step_q) && act[i]) eff = 3'(i);
    end
  end

  // width of the field due now
  always_comb begin
    case (phase_q)
      PH_HEADER: w = 5'd8;
      PH_HEAD:   w = 5'd6;
      PH_CHANGE: begin
        if (eff == 3'd0)      w = 5'd5;
        else if (eff <= 3'd2) w = dw_q;
        else if (eff <= 3'd4) w = {1'b0, fib_q};
        else                  w = {1'b0, lib_q};
      end
      PH_LINE:   w = (step_q == 4'd0 || step_q == 4'd3) ? 5'd1 : dw_q;
      default:   w = dw_q;
    endcase
  end

  // field extraction, msb first
  assign stop       = (n_q == 2'd2) || (phase_q == PH_DONE);
  assign change_fin = (phase_q == PH_CHANGE) && (eff == 3'd6);
  assign short      = held_q < {1'b0, w};
  assign sh         = held_q - {1'b0, w};
  assign shifted    = buf_q >> sh;
  assign v          = shifted[31:0] & ((32'd1 << w) - 32'd1);
  assign sx         = CW'(sext(v, dw_q));
  assign end_byte   = run_q && (stop || (!change_fin && short));

  // parser step, result pairing and byte load
  always_comb begin
    buf_d      = buf_q;
    held_d     = held_q;
    phase_d    = phase_q;
    step_d     = step_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    dw_d       = dw_q;
    flags_d    = flags_q;
    f0_d       = f0_q;
    f1_d       = f1_q;
    ln_d       = ln_q;
    fib_d      = fib_q;
    lib_d      = lib_q;
    run_d      = run_q;
    n_d        = n_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    emit       = 1'b0;
    emit_kind  = KIND_CHANGE;
    emit_ctrl  = 1'b0;
    res_push_o = 1'b0;
    res_o      = pend_q;
    byte_pop_o = 1'b0;
    new_res    = pend_q;

    if (en && run_q && !end_byte) begin
      if (change_fin) begin
        emit      = 1'b1;
        emit_kind = KIND_CHANGE;
        step_d    = 4'd0;
        if (flags_q[4]) begin
          held_d  = {held_q[HeldWidth-1:3], 3'b000};
          phase_d = PH_HEADER;
        end else begin
          phase_d = PH_HEAD;
        end
      end else begin
        held_d = sh;
        case (phase_q)
          PH_HEADER: begin
            fib_d     = v[7:4];
            lib_d     = v[3:0];
            emit      = 1'b1;
            emit_kind = KIND_HEADER;
            phase_d   = PH_HEAD;
          end
          PH_HEAD: begin
            step_d = 4'd0;
            if (v[5:0] == 6'd0) begin
              emit      = 1'b1;
              emit_kind = KIND_END;
              phase_d   = PH_DONE;
              held_d    = '0;
            end else if (!v[5]) begin
              flags_d = v[4:0];
              phase_d = PH_CHANGE;
            end else begin
              dw_d    = {1'b0, v[3:0]} + 5'd2;
              cx_d    = cur_x_q;
              cy_d    = cur_y_q;
              phase_d = v[4] ? PH_LINE : PH_CURVE;
            end
          end
          PH_CHANGE: begin
            case (eff)
              3'd0:    dw_d    = v[4:0];
              3'd1:    cur_x_d = sx;
              3'd2:    cur_y_d = sx;
              3'd3:    f0_d    = v[14:0];
              3'd4:    f1_d    = v[14:0];
              default: ln_d    = v[14:0];
            endcase
            step_d = {1'b0, eff} + 4'd1;
          end
          PH_LINE: begin
            if (step_q == 4'd0) begin
              step_d = v[0] ? 4'd1 : 4'd3;
            end else if (step_q == 4'd1) begin
              cur_x_d = cur_x_q + sx;
              step_d  = 4'd2;
            end else if (step_q == 4'd3) begin
              flags_d = {4'b0, v[0]};
              step_d  = 4'd4;
            end else begin
              if (step_q == 4'd2 || flags_q[0]) cur_y_d = cur_y_q + sx;
              else                              cur_x_d = cur_x_q + sx;
              emit      = 1'b1;
              emit_kind = KIND_EDGE;
              emit_ctrl = 1'b1;
              step_d    = 4'd0;
              phase_d   = PH_HEAD;
            end
          end
          default: begin
            if (step_q == 4'd0)      cx_d    = cur_x_q + sx;
            else if (step_q == 4'd1) cy_d    = cur_y_q + sx;
            else if (step_q == 4'd2) cur_x_d = cx_q + sx;
            else                     cur_y_d = cy_q + sx;
            if (step_q >= 4'd3) begin
              emit      = 1'b1;
              emit_kind = KIND_CURVE;
              emit_ctrl = 1'b1;
              step_d    = 4'd0;
              phase_d   = PH_HEAD;
            end else begin
              step_d = step_q + 4'd1;
            end
          end
        endcase
      end
    end

    // new result from the updated state, the earlier one leaves as not last
    new_res.record_kind  = emit_kind;
    new_res.pos_x_out    = 32'(cur_x_d);
    new_res.pos_y_out    = 32'(cur_y_d);
    new_res.ctrl_x_out   = emit_ctrl ? 32'(cx_d) : 32'sd0;
    new_res.ctrl_y_out   = emit_ctrl ? 32'(cy_d) : 32'sd0;
    new_res.fill_left    = f0_d;
    new_res.fill_right   = f1_d;
    new_res.stroke_style = ln_d;
    new_res.style_error  = (f0_d > 15'd1) || (f1_d > 15'd1) || (ln_d != 15'd0);
    new_res.last         = 1'b0;
    if (emit) begin
      res_push_o = pend_vld_q;
      res_o      = pend_q;
      pend_d     = new_res;
      pend_vld_d = 1'b1;
      n_d        = n_q + 2'd1;
    end

    // byte done: last pending result leaves marked last
    if (en && end_byte) begin
      res_push_o = pend_vld_q;
      res_o      = pend_q;
      res_o.last = 1'b1;
      pend_vld_d = 1'b0;
      run_d      = 1'b0;
    end

    // take the next byte
    if (en && (!run_q || end_byte) && byte_valid_i) begin
      byte_pop_o = 1'b1;
      if (byte_i.start_shape) begin
        buf_d   = {32'd0, byte_i.data_byte};
        held_d  = 6'd8;
        phase_d = PH_HEADER;
        step_d  = 4'd0;
        cur_x_d = '0;
        cur_y_d = '0;
        cx_d    = '0;
        cy_d    = '0;
        dw_d    = '0;
        flags_d = '0;
        f0_d    = '0;
        f1_d    = '0;
        ln_d    = '0;
        fib_d   = '0;
        lib_d   = '0;
        run_d   = 1'b1;
        n_d     = 2'd0;
      end else if (phase_d != PH_DONE) begin
        buf_d  = {buf_d[BufWidth-9:0], byte_i.data_byte};
        held_d = (held_d > 6'd32) ? BufBits : held_d + 6'd8;
        run_d  = 1'b1;
        n_d    = 2'd0;
      end
    end
  end

  // payload of the pending result
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q      <= '0;
      held_q     <= '0;
      phase_q    <= PH_HEADER;
      step_q     <= '0;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      cx_q       <= '0;
      cy_q       <= '0;
      dw_q       <= '0;
      flags_q    <= '0;
      f0_q       <= '0;
      f1_q       <= '0;
      ln_q       <= '0;
      fib_q      <= '0;
      lib_q      <= '0;
      run_q      <= 1'b0;
      n_q        <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      buf_q      <= buf_d;
      held_q     <= held_d;
      phase_q    <= phase_d;
      step_q     <= step_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      cx_q       <= cx_d;
      cy_q       <= cy_d;
      dw_q       <= dw_d;
      flags_q    <= flags_d;
      f0_q       <= f0_d;
      f1_q       <= f1_d;
      ln_q       <= ln_d;
      fib_q      <= fib_d;
      lib_q      <= lib_d;
      run_q      <= run_d;
      n_q        <= n_d;
      pend_vld_q <= pend_vld_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/vector_shape_record_decoder.sv =====
// A byte passes through the front queue and loads into the accumulator once the parser is
// free; the parser then completes its fields and records in turn while the output queue has
// room. A result is held as pending, enters the output queue with the next result or at
// byte end, and is offered from there. A byte holds the parser until it ends, and the next
// byte loads in the cycle in which the previous byte ends.
// Reset: rst_ni low clears queues, accumulator, position and styles at once; then a header.
`default_nettype none
module vector_shape_record_decoder
  import vsrd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [7:0]   s_axis_tdata,  // data_byte
  input  wire          s_axis_tuser,  // start_shape
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // pos_x_out, pos_y_out, ctrl_x_out, ctrl_y_out, fill_left, fill_right,
  // stroke_style, style_error, two zero bits
  output logic [175:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,  // record_kind
  output logic         m_axis_tlast   // last
);

  logic    in_full, byte_valid, byte_pop, out_full, res_push;
  byte_t   in_byte, byte_q;
  result_t res, res_out;

  assign s_axis_tready       = !in_full;
  assign in_byte.start_shape = s_axis_tuser;
  assign in_byte.data_byte   = s_axis_tdata;

  // front: byte queue
  vsrd_byte_queue u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid && s_axis_tready),
    .push_data_i (in_byte),
    .full_o      (in_full),
    .pop_i       (byte_pop),
    .valid_o     (byte_valid),
    .data_o      (byte_q)
  );

  // back: record parser
  vsrd_engine #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_q),
    .byte_pop_o   (byte_pop),
    .out_full_i   (out_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // output queue
  vsrd_result_queue u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .full_o      (out_full),
    .pop_i       (m_axis_tvalid && m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (res_out)
  );

  // output packing
  assign m_axis_tdata = {2'b00, res_out.style_error, res_out.stroke_style,
                         res_out.fill_right, res_out.fill_left,
                         res_out.ctrl_y_out, res_out.ctrl_x_out,
                         res_out.pos_y_out, res_out.pos_x_out};
  assign m_axis_tuser = res_out.record_kind;
  assign m_axis_tlast = res_out.last;

endmodule
`default_nettype wire

// ===== src/vsrd_checker.sv =====
// port-level checks of the shape record decoder and their binding
`default_nettype none
module vsrd_checker
  import vsrd_pkg::*;
(
  input wire         clk_i,
  input wire         rst_ni,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [175:0] m_axis_tdata,
  input wire [2:0]   m_axis_tuser,
  input wire         m_axis_tlast
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // end record closes its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_END) |-> m_axis_tlast)
    else $error("end record not last");

  // only edges and curves carry a control point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_CHANGE || m_axis_tuser == KIND_HEADER
      || m_axis_tuser == KIND_END) |-> (m_axis_tdata[127:64] == 64'd0))
    else $error("control point on non-edge record");

  // style error matches reported indices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[173] == ((m_axis_tdata[142:128] > 15'd1)
      || (m_axis_tdata[157:143] > 15'd1) || (m_axis_tdata[172:158] != 15'd0)))
    else $error("style error flag inconsistent");

endmodule

bind vector_shape_record_decoder vsrd_checker u_vsrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
